// ===== rtl/tsta_pkg.sv =====
// Shared types and constants of the train spacing table advisor.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tsta_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_ADVISE = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] MODE_HEAD = 2'd0;
    localparam logic [1:0] MODE_STOP = 2'd1;
    localparam logic [1:0] MODE_SLOW = 2'd2;
    localparam logic [1:0] MODE_REG  = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIMAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd4;

    localparam logic [7:0]  ADV_MAX     = 8'd250;
    localparam logic [12:0] SLOW_RECIP  = 13'd6554;
    localparam logic [15:0] LIMIT_SCALE = 16'd64000;

    typedef enum logic [4:0] {
        OP_IDLE, OP_START, OP_SCAN, OP_SCAN_END, OP_DECIDE,
        OP_SHIFT_RD, OP_SHIFT_WR, OP_INSERT, OP_REPORT,
        OP_RD_PREV, OP_RD_CUR, OP_DIST, OP_MODE, OP_MUL,
        OP_SAT, OP_DIV_INIT, OP_DIV, OP_ROUND, OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_ctrl_cmd;

    typedef struct packed {
        logic count_zero;
        logic addr_last;
        logic at_j;
        logic do_shift;
        logic do_report;
        logic do_adv;
        logic need_div;
        logic sat;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/tsta_ctrl.sv =====
// Controller state machine of the train spacing table advisor.
// Sequences search, shift, insert and advice steps; depends on tsta_pkg.
`default_nettype none

module tsta_ctrl import tsta_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_SCAN_END, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
        S_INSERT, S_REPORT, S_RD_PREV, S_RD_CUR, S_DIST, S_MODE,
        S_BRANCH, S_MUL, S_CMP, S_DIV, S_ROUND, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_dp_op op;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.op = op;

    always_comb begin
        n_state = r_state;
        op = OP_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op = OP_START;
                    n_state = i_stat.count_zero ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                op = OP_SCAN;
                if (i_stat.addr_last) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                op = OP_SCAN_END;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                op = OP_DECIDE;
                if (i_stat.do_shift) n_state = S_SHIFT_RD;
                else if (i_stat.do_report) n_state = S_REPORT;
                else if (i_stat.do_adv) n_state = S_RD_PREV;
                else n_state = S_DONE;
            end
            S_SHIFT_RD: begin
                if (i_stat.at_j) begin
                    n_state = S_INSERT;
                end else begin
                    op = OP_SHIFT_RD;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                op = OP_SHIFT_WR;
                n_state = S_SHIFT_RD;
            end
            S_INSERT: begin
                op = OP_INSERT;
                n_state = S_DONE;
            end
            S_REPORT: begin
                op = OP_REPORT;
                n_state = S_DONE;
            end
            S_RD_PREV: begin
                op = OP_RD_PREV;
                n_state = S_RD_CUR;
            end
            S_RD_CUR: begin
                op = OP_RD_CUR;
                n_state = S_DIST;
            end
            S_DIST: begin
                op = OP_DIST;
                n_state = S_MODE;
            end
            S_MODE: begin
                op = OP_MODE;
                n_state = S_BRANCH;
            end
            S_BRANCH: begin
                n_state = i_stat.need_div ? S_MUL : S_DONE;
            end
            S_MUL: begin
                op = OP_MUL;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.sat) begin
                    op = OP_SAT;
                    n_state = S_DONE;
                end else begin
                    op = OP_DIV_INIT;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                op = OP_DIV;
                if (i_stat.div_last) n_state = S_ROUND;
            end
            S_ROUND: begin
                op = OP_ROUND;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    op = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("A second transaction could enter while one was in work.");

endmodule

`default_nettype wire

// ===== rtl/tsta_dp.sv =====
// Datapath of the train spacing table advisor: train table memory, search,
// shift, spacing arithmetic, divider and result register; depends on tsta_pkg.
`default_nettype none

module tsta_dp import tsta_pkg::*; #(
    parameter int MAX_TRAINS = 128,
    parameter int ID_BITS    = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctrl_cmd            i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic [1:0]           i_command,
    input  wire logic [63:0]          i_train_id,
    input  wire logic [15:0]          i_location,
    input  wire logic [9:0]           i_speed,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [1:0]                o_status,
    output logic [6:0]                o_entry_index,
    output logic [7:0]                o_advised_speed,
    output logic [1:0]                o_advice_mode,
    output logic [7:0]                o_train_count
);

    localparam int IW = $clog2(MAX_TRAINS);
    localparam int CW = $clog2(MAX_TRAINS + 1);
    localparam int EW = ID_BITS + 26;

    logic [EW-1:0] mem [MAX_TRAINS];

    logic [15:0] r_track, r_optimal, r_stop, r_slow_d;
    logic [23:0] r_gain;

    t_cmd                r_cmd;
    logic [ID_BITS-1:0]  r_id;
    logic [15:0]         r_loc;
    logic [9:0]          r_spd;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;
    logic [EW-1:0]       r_rd_data;
    logic                r_found, r_jfound;
    logic [IW-1:0]       r_f;
    logic [CW-1:0]       r_j;
    logic [1:0]          r_res_status;
    logic [IW-1:0]       r_res_idx;
    logic [7:0]          r_adv;
    logic [1:0]          r_mode;
    logic [15:0]         r_pp;
    logic [9:0]          r_pv;
    logic signed [17:0]  r_d;
    logic [7:0]          r_slow;
    logic                r_need_div;
    logic [15:0]         r_abs_e;
    logic [33:0]         r_num;
    logic [31:0]         r_lim;
    logic [33:0]         r_rem;
    logic [7:0]          r_q;
    logic [2:0]          r_cnt;
    logic                r_out_valid;

    logic                rd_en, wr_en;
    logic [IW-1:0]       rd_addr, wr_addr;
    logic [EW-1:0]       wr_data;
    logic [ID_BITS-1:0]  rd_id;
    logic [15:0]         rd_pos;
    logic [9:0]          rd_vel;
    logic                full;
    logic [15:0]         dist_a;
    logic signed [17:0]  dist_b, dist_d;
    logic [13:0]         slow_x;
    logic [26:0]         slow_p;
    logic [10:0]         slow_q;
    logic signed [18:0]  err_e;
    logic [33:0]         trial;
    logic [23:0]         den;
    logic                round_up;
    t_dp_op              op;

    assign op     = i_cmd.op;
    assign rd_id  = r_rd_data[EW-1:26];
    assign rd_pos = r_rd_data[25:10];
    assign rd_vel = r_rd_data[9:0];
    assign full   = (r_count == CW'(MAX_TRAINS));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = {r_id, r_loc, r_spd};
        case (op)
            OP_SCAN: rd_en = 1'b1;
            OP_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_addr - IW'(1);
            end
            OP_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_data = r_rd_data;
            end
            OP_INSERT: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IW-1:0];
            end
            OP_REPORT: begin
                wr_en   = 1'b1;
                wr_addr = r_f;
            end
            OP_RD_PREV: begin
                rd_en   = 1'b1;
                rd_addr = r_f - IW'(1);
            end
            OP_RD_CUR: begin
                rd_en   = 1'b1;
                rd_addr = r_f;
            end
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        dist_a = (r_pp > rd_pos) ? (r_pp - rd_pos) : (rd_pos - r_pp);
        dist_b = $signed({2'b00, r_track}) - $signed({2'b00, dist_a});
        dist_d = (dist_b > $signed({2'b00, dist_a})) ? $signed({2'b00, dist_a}) : dist_b;
        slow_x = 14'(r_pv) * 14'd9 + 14'd5;
        slow_p = 27'(slow_x) * 27'(SLOW_RECIP);
        slow_q = slow_p[26:16];
        err_e  = $signed({3'b000, r_optimal}) - 19'(r_d);
        trial  = 34'({r_abs_e, 8'b0}) << r_cnt;
        den    = {r_abs_e, 8'b0};
        round_up = ({r_rem, 1'b0} >= 35'(den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track     <= 16'd10000;
            r_optimal   <= 16'd1000;
            r_stop      <= 16'd200;
            r_slow_d    <= 16'd500;
            r_gain      <= 24'd256000;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRACK:   r_track   <= i_cfg_data[15:0];
                    CFG_OPTIMAL: r_optimal <= i_cfg_data[15:0];
                    CFG_STOP:    r_stop    <= i_cfg_data[15:0];
                    CFG_SLOW:    r_slow_d  <= i_cfg_data[15:0];
                    CFG_GAIN:    r_gain    <= i_cfg_data;
                    default:     r_gain    <= r_gain;
                endcase
            end
            r_rd_vld <= (op == OP_SCAN);
            if (op == OP_INSERT) r_count <= r_count + CW'(1);
            if (op == OP_OUT) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && (op == OP_SCAN || op == OP_SCAN_END)) begin
            if (rd_id == r_id && !r_found) begin
                r_found <= 1'b1;
                r_f     <= r_rd_idx;
            end
            if (rd_pos > r_loc && !r_jfound) begin
                r_jfound <= 1'b1;
                r_j      <= CW'(r_rd_idx);
            end
        end
        case (op)
            OP_START: begin
                r_cmd    <= t_cmd'(i_command);
                r_id     <= i_train_id[ID_BITS-1:0];
                r_loc    <= i_location;
                r_spd    <= i_speed;
                r_addr   <= '0;
                r_found  <= 1'b0;
                r_jfound <= 1'b0;
                r_j      <= r_count;
            end
            OP_SCAN: begin
                r_addr   <= r_addr + IW'(1);
                r_rd_idx <= r_addr;
            end
            OP_DECIDE: begin
                r_addr <= r_count[IW-1:0];
                r_mode <= MODE_HEAD;
                r_adv  <= (r_cmd == CMD_ADVISE && r_found && r_f == '0) ? ADV_MAX : '0;
                case (r_cmd)
                    CMD_ADD: begin
                        r_res_status <= (!r_found && full) ? ST_FULL : ST_OK;
                        r_res_idx <= r_found ? r_f : (full ? '0 : r_j[IW-1:0]);
                    end
                    CMD_REPORT, CMD_ADVISE: begin
                        r_res_status <= r_found ? ST_OK : ST_NOT_FOUND;
                        r_res_idx <= r_found ? r_f : '0;
                    end
                    default: begin
                        r_res_status <= ST_OK;
                        r_res_idx <= '0;
                    end
                endcase
            end
            OP_SHIFT_WR: r_addr <= r_addr - IW'(1);
            OP_RD_CUR: begin
                r_pp <= rd_pos;
                r_pv <= rd_vel;
            end
            OP_DIST: begin
                r_d    <= dist_d;
                r_slow <= (slow_q > 11'(ADV_MAX)) ? ADV_MAX : slow_q[7:0];
            end
            OP_MODE: begin
                r_abs_e <= err_e[18] ? 16'(-err_e) : err_e[15:0];
                if (r_d < $signed({2'b00, r_stop})) begin
                    r_mode     <= MODE_STOP;
                    r_adv      <= '0;
                    r_need_div <= 1'b0;
                end else if (r_d < $signed({2'b00, r_slow_d})) begin
                    r_mode     <= MODE_SLOW;
                    r_adv      <= r_slow;
                    r_need_div <= 1'b0;
                end else begin
                    r_mode     <= MODE_REG;
                    r_need_div <= (err_e != '0);
                    if (err_e == '0) r_adv <= ADV_MAX;
                end
            end
            OP_MUL: begin
                r_num <= {10'b0, r_gain} * {24'b0, r_pv};
                r_lim <= r_abs_e * LIMIT_SCALE;
            end
            OP_SAT: r_adv <= ADV_MAX;
            OP_DIV_INIT: begin
                r_rem <= r_num;
                r_q   <= '0;
                r_cnt <= 3'd7;
            end
            OP_DIV: begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_q[r_cnt] <= 1'b1;
                end
                r_cnt <= r_cnt - 3'd1;
            end
            OP_ROUND: r_adv <= r_q + 8'(round_up);
            OP_OUT: begin
                o_status        <= r_res_status;
                o_entry_index   <= 7'(r_res_idx);
                o_advised_speed <= r_adv;
                o_advice_mode   <= r_mode;
                o_train_count   <= 8'(r_count);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.addr_last  = ((CW'(r_addr) + CW'(1)) == r_count);
        o_stat.at_j       = (CW'(r_addr) == r_j);
        o_stat.do_shift   = (r_cmd == CMD_ADD) && !r_found && !full;
        o_stat.do_report  = (r_cmd == CMD_REPORT) && r_found;
        o_stat.do_adv     = (r_cmd == CMD_ADVISE) && r_found && (r_f != '0);
        o_stat.need_div   = r_need_div;
        o_stat.sat        = (r_num > 34'(r_lim));
        o_stat.div_last   = (r_cnt == 3'd0);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TRAINS))
        else $error("Train count exceeds the table depth.");

    a_adv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_advised_speed <= ADV_MAX))
        else $error("Advised speed above the saturation limit.");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_advice_mode == MODE_STOP) |-> (o_advised_speed == 8'd0))
        else $error("Emergency stop advice with a nonzero speed.");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_INSERT) |-> !full)
        else $error("Insert into a full table.");

endmodule

`default_nettype wire

// ===== rtl/train_spacing_table_advisor_top.sv =====
// Top level of the train spacing table advisor.
// Joins tsta_ctrl and tsta_dp; depends on tsta_pkg.
//
// Usage: one command transaction enters on the input channel (valid/stall)
// and produces exactly one result transaction on the output channel.
// Commands are add, location report and speed advice; the table keeps up
// to MAX_TRAINS trains, each new train inserted in ascending location order.
// Configuration registers must be written by the user through i_cfg_we,
// i_cfg_index, i_cfg_data while no command is in work; the block has no check.
// Every command first scans the held entries, one per cycle. An add of a new
// train then shifts each entry above its slot with a read and a write step.
// An advice for a train behind the head then reads the previous and the
// current entry, finds the distance and the mode and, under the gain law,
// runs its 8-step restoring divider and rounds, unless the result saturates.
// One command is in work at a time.
// The input stalls while a command is in work; the result register frees the
// block to take the next command while a result waits to be taken.
// If the receiver stalls, the result holds and the next result waits.
// Reset empties the table and loads the default configuration.
`default_nettype none

module train_spacing_table_advisor_top import tsta_pkg::*; #(
    parameter int MAX_TRAINS = 128,
    parameter int ID_BITS    = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_command,
    input  wire logic [63:0]          i_train_id,
    input  wire logic [15:0]          i_location,
    input  wire logic [9:0]           i_speed,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_status,
    output logic [6:0]                o_entry_index,
    output logic [7:0]                o_advised_speed,
    output logic [1:0]                o_advice_mode,
    output logic [7:0]                o_train_count
);

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    tsta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    tsta_dp #(
        .MAX_TRAINS (MAX_TRAINS),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_train_id      (i_train_id),
        .i_location      (i_location),
        .i_speed         (i_speed),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index),
        .o_advised_speed (o_advised_speed),
        .o_advice_mode   (o_advice_mode),
        .o_train_count   (o_train_count)
    );

endmodule

`default_nettype wire

// ===== dv/train_spacing_table_advisor_top_tb.sv =====
// Testbench for train_spacing_table_advisor_top: random and directed commands
// checked against a behavioral table model in a small scoreboard class.
// Depends on tsta_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none

module train_spacing_table_advisor_top_tb import tsta_pkg::*;;

    localparam int TABLE_DEPTH = 128;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] entry_index;
        logic [7:0] advised_speed;
        logic [1:0] advice_mode;
        logic [7:0] train_count;
    } t_outcome;

    class spacing_scoreboard;
        logic [15:0] track_len, opt_dist, stop_dist, slow_dist;
        logic [23:0] gain;
        logic [63:0] ident[TABLE_DEPTH];
        logic [15:0] posn[TABLE_DEPTH];
        logic [9:0]  velo[TABLE_DEPTH];
        int          count;
        t_outcome    pending[$];
        int          errors;

        function new();
            track_len = 16'd10000;
            opt_dist  = 16'd1000;
            stop_dist = 16'd200;
            slow_dist = 16'd500;
            gain      = 24'd256000;
            count     = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_TRACK:   track_len = val[15:0];
                CFG_OPTIMAL: opt_dist  = val[15:0];
                CFG_STOP:    stop_dist = val[15:0];
                CFG_SLOW:    slow_dist = val[15:0];
                CFG_GAIN:    gain      = val;
                default: ;
            endcase
        endfunction

        function int lookup(logic [63:0] id);
            for (int i = 0; i < count; i++)
                if (ident[i] == id) return i;
            return -1;
        endfunction

        function logic [7:0] spacing_advice(int idx, output logic [1:0] mode);
            longint p1, p2, v1, a, b, d, e, num, den, r;
            p1 = posn[idx-1];
            p2 = posn[idx];
            v1 = velo[idx-1];
            a = (p1 > p2) ? p1 - p2 : p2 - p1;
            b = longint'(track_len) - a;
            d = (b > a) ? a : b;
            e = longint'(opt_dist) - d;
            if (d < longint'(stop_dist)) begin
                mode = MODE_STOP;
                return 8'd0;
            end
            if (d < longint'(slow_dist)) begin
                mode = MODE_SLOW;
                r = (v1 * 9 + 5) / 10;
                return (r > 250) ? ADV_MAX : r[7:0];
            end
            mode = MODE_REG;
            if (e == 0) return ADV_MAX;
            if (e < 0) e = -e;
            num = longint'(gain) * v1;
            den = e * 256;
            if (num > den * 250) return ADV_MAX;
            r = (2 * num + den) / (2 * den);
            return (r > 250) ? ADV_MAX : r[7:0];
        endfunction

        function void note_command(logic [1:0] cmd, logic [63:0] id, logic [15:0] loc,
                                   logic [9:0] spd);
            t_outcome o;
            int       f, j;
            o = '0;
            f = lookup(id);
            case (cmd)
                CMD_ADD: begin
                    if (f >= 0) o.entry_index = 7'(f);
                    else if (count >= TABLE_DEPTH) o.status = ST_FULL;
                    else begin
                        j = count;
                        for (int i = 0; i < count; i++)
                            if (posn[i] > loc) begin
                                j = i;
                                break;
                            end
                        for (int i = count; i > j; i--) begin
                            ident[i] = ident[i-1];
                            posn[i]  = posn[i-1];
                            velo[i]  = velo[i-1];
                        end
                        ident[j] = id;
                        posn[j]  = loc;
                        velo[j]  = spd;
                        count++;
                        o.entry_index = 7'(j);
                    end
                end
                CMD_REPORT: begin
                    if (f < 0) o.status = ST_NOT_FOUND;
                    else begin
                        o.entry_index = 7'(f);
                        posn[f] = loc;
                        velo[f] = spd;
                    end
                end
                CMD_ADVISE: begin
                    if (f < 0) o.status = ST_NOT_FOUND;
                    else begin
                        o.entry_index = 7'(f);
                        if (f == 0) begin
                            o.advised_speed = ADV_MAX;
                            o.advice_mode   = MODE_HEAD;
                        end else begin
                            o.advised_speed = spacing_advice(f, o.advice_mode);
                        end
                    end
                end
                default: ;
            endcase
            o.train_count = 8'(count);
            pending.push_back(o);
        endfunction

        function void check_result(t_outcome got);
            t_outcome exp;
            if (pending.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.entry_index !== exp.entry_index) begin
                $error("entry_index: expected %0d, got %0d", exp.entry_index,
                       got.entry_index);
                errors++;
            end
            if (got.advised_speed !== exp.advised_speed) begin
                $error("advised_speed: expected %0d, got %0d", exp.advised_speed,
                       got.advised_speed);
                errors++;
            end
            if (got.advice_mode !== exp.advice_mode) begin
                $error("advice_mode: expected %0d, got %0d", exp.advice_mode,
                       got.advice_mode);
                errors++;
            end
            if (got.train_count !== exp.train_count) begin
                $error("train_count: expected %0d, got %0d", exp.train_count,
                       got.train_count);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           command = '0;
    logic [63:0]          train_id = '0;
    logic [15:0]          location = '0;
    logic [9:0]           speed = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           res_status;
    logic [6:0]           res_entry_index;
    logic [7:0]           res_advised_speed;
    logic [1:0]           res_advice_mode;
    logic [7:0]           res_train_count;
    t_outcome             result;
    spacing_scoreboard    board;
    logic                 long_hold = 1'b0;
    logic [63:0]          known_ids[$];

    always #5 clk = ~clk;

    assign result = {res_status, res_entry_index, res_advised_speed, res_advice_mode,
                     res_train_count};

    train_spacing_table_advisor_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_train_id     (train_id),
        .i_location     (location),
        .i_speed        (speed),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (res_status),
        .o_entry_index  (res_entry_index),
        .o_advised_speed(res_advised_speed),
        .o_advice_mode  (res_advice_mode),
        .o_train_count  (res_train_count)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_command(logic [1:0] cmd, logic [63:0] id, logic [15:0] loc,
                                logic [9:0] spd);
        int gap;
        gap = gap_length();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        train_id <= id;
        location <= loc;
        speed    <= spd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_command(cmd, id, loc, spd);
        if (cmd == CMD_ADD && board.count > known_ids.size()) known_ids.push_back(id);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (3 * TABLE_DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_id();
        if (known_ids.size() != 0 && $urandom_range(0, 9) < 8)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int n, int loc_max);
        logic [1:0] cmd;
        int         r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) cmd = CMD_ADD;
            else if (r < 55) cmd = CMD_REPORT;
            else if (r < 97) cmd = CMD_ADVISE;
            else cmd = CMD_UNUSED;
            send_command(cmd, pick_id(), 16'($urandom_range(0, loc_max)),
                         10'($urandom_range(0, 1023)));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_result(result);
    end

    initial begin
        int r;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                out_stall <= (r < 25) || (r > 97);
                if (r > 97) begin
                    repeat ($urandom_range(10, 50)) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_ADVISE, 64'h0, 16'd0, 10'd0);
        send_command(CMD_REPORT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 10'h3FF);
        send_command(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd5000, 10'h3FF);
        send_command(CMD_ADD, 64'h0, 16'd0, 10'd0);
        send_command(CMD_ADD, 64'h1, 16'd5100, 10'd100);
        send_command(CMD_ADD, 64'h2, 16'd5500, 10'd200);
        send_command(CMD_ADD, 64'h3, 16'd6500, 10'd300);
        send_command(CMD_ADD, 64'h4, 16'd8000, 10'd1);
        send_command(CMD_ADD, 64'h1, 16'd9, 10'd9);
        send_command(CMD_ADVISE, 64'h0, 16'd0, 10'd0);
        send_command(CMD_ADVISE, 64'h1, 16'd0, 10'd0);
        send_command(CMD_ADVISE, 64'h2, 16'd0, 10'd0);
        send_command(CMD_ADVISE, 64'h3, 16'd0, 10'd0);
        send_command(CMD_ADVISE, 64'h4, 16'd0, 10'd0);
        send_command(CMD_ADVISE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 10'd0);
        send_command(CMD_REPORT, 64'h2, 16'hFFFF, 10'd0);
        send_command(CMD_ADVISE, 64'h2, 16'd0, 10'd0);
        send_command(CMD_UNUSED, 64'h3, 16'd1, 10'd1);
        send_command(CMD_ADVISE, 64'h5, 16'd0, 10'd0);
        drain_results();

        write_reg(CFG_TRACK, 24'd65535);
        write_reg(CFG_OPTIMAL, 24'd0);
        write_reg(CFG_STOP, 24'd0);
        write_reg(CFG_SLOW, 24'd0);
        write_reg(CFG_GAIN, 24'hFFFFFF);
        random_phase(250, 65535);
        drain_results();

        write_reg(CFG_TRACK, 24'd1);
        write_reg(CFG_OPTIMAL, 24'd65535);
        write_reg(CFG_STOP, 24'd65535);
        write_reg(CFG_SLOW, 24'd65535);
        write_reg(CFG_GAIN, 24'd0);
        random_phase(100, 65535);
        drain_results();

        write_reg(CFG_TRACK, 24'd4000);
        write_reg(CFG_OPTIMAL, 24'd300);
        write_reg(CFG_STOP, 24'd20);
        write_reg(CFG_SLOW, 24'd60);
        write_reg(CFG_GAIN, 24'd4096);
        long_hold = 1'b1;
        random_phase(500, 4000);
        drain_results();

        write_reg(CFG_TRACK, 24'd10000);
        write_reg(CFG_OPTIMAL, 24'd1000);
        write_reg(CFG_STOP, 24'd200);
        write_reg(CFG_SLOW, 24'd500);
        write_reg(CFG_GAIN, 24'd256000);
        random_phase(650, 12000);
        drain_results();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
